// ===== rtl/bse_pkg.sv =====
// Shared types and constants for the bubble sort engine.
// No dependencies; used by the channel interfaces and the top level.
`timescale 1ns / 1ps

package bse_pkg;

   localparam int VALUE_W    = 32;
   localparam int CSR_DATA_W = 32;
   localparam int CSR_ADDR_W = 3;

   typedef logic signed [VALUE_W-1:0] value_type;
   typedef logic [CSR_ADDR_W-3:0]     reg_index_type;

   // word index of each control register
   localparam reg_index_type REG_DESCENDING = reg_index_type'(0);

endpackage

// ===== rtl/bse_req_if.sv =====
// Input channel of the bubble sort engine: one element per item.
// Depends on bse_pkg.
`timescale 1ns / 1ps

interface bse_req_if;
   logic               valid;
   logic               ready;
   bse_pkg::value_type value;
   logic               last_in;

   modport source (output valid, output value, output last_in, input ready);
   modport sink   (input valid, input value, input last_in, output ready);
endinterface

// ===== rtl/bse_rsp_if.sv =====
// Result channel of the bubble sort engine: one sorted element per item.
// Depends on bse_pkg.
`timescale 1ns / 1ps

interface bse_rsp_if;
   logic               valid;
   logic               ready;
   bse_pkg::value_type sorted_value;
   logic               last_out;
   logic               dropped;

   modport source (output valid, output sorted_value, output last_out, output dropped,
                   input ready);
   modport sink   (input valid, input sorted_value, input last_out, input dropped,
                   output ready);
endinterface

// ===== rtl/bse_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module bse_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

// ===== rtl/bubble_sort_engine.sv =====
// Bubble sort engine: collects a set of signed 32-bit elements, one per input item, into a
// RAM of MAX_ITEMS entries. Items are loaded while the engine is idle. The item flagged last_in
// starts the sort: each pass walks the RAM through a single compare unit fed by the one RAM
// read port, one compare-swap per cycle, and each pass is one element shorter than the last.
// The sorted set then leaves one result item at a time: a RAM read (S_OREAD), a load into
// the result register (S_OLOAD), then S_OSEND, which holds until rsp ready.
// Input is not ready while sorting or sending.
// Elements beyond MAX_ITEMS are discarded and every result of that set carries dropped.
// Register 0 (byte address 0), bit 0: descending (0 ascending, 1 descending), reset 0.
// Depends on bse_pkg, bse_req_if, bse_rsp_if and bse_ram.
`timescale 1ns / 1ps

module bubble_sort_engine #(
   parameter int MAX_ITEMS = 64
) (
   input  logic                               clock,
   input  logic                               reset,
   bse_req_if.sink                            req_chan,
   bse_rsp_if.source                          rsp_chan,
   input  logic                               csr_psel,
   input  logic                               csr_penable,
   input  logic                               csr_pwrite,
   input  logic [bse_pkg::CSR_ADDR_W-1:0]     csr_paddr,
   input  logic [bse_pkg::CSR_DATA_W-1:0]     csr_pwdata,
   output logic [bse_pkg::CSR_DATA_W-1:0]     csr_prdata,
   output logic                               csr_pready
);

   localparam int AW = $clog2(MAX_ITEMS);
   localparam int CW = $clog2(MAX_ITEMS + 1);
   localparam logic [CW-1:0] MAX_COUNT = CW'(MAX_ITEMS);

   typedef enum logic [2:0] {
      S_IDLE,
      S_START,
      S_CARRY,
      S_RUN,
      S_TAIL,
      S_OREAD,
      S_OLOAD,
      S_OSEND
   } state_type;

   state_type          state_ff, state_in;
   logic [CW-1:0]      count_ff, count_in;
   logic               overflow_ff, overflow_in;
   logic               descending_ff, descending_in;
   logic [CW-1:0]      span_ff, span_in;     // length of the current pass
   logic [AW-1:0]      k_ff, k_in;           // position being compared
   logic [AW-1:0]      idx_ff, idx_in;       // output position
   bse_pkg::value_type carry_ff, carry_in;   // element bubbling through the pass
   logic               rsp_valid_ff, rsp_valid_in;
   bse_pkg::value_type rsp_value_ff, rsp_value_in;
   logic               rsp_last_ff, rsp_last_in;
   logic               rsp_drop_ff, rsp_drop_in;

   logic               ram_we;
   logic [AW-1:0]      ram_waddr;
   bse_pkg::value_type ram_wdata;
   logic [AW-1:0]      ram_raddr;
   bse_pkg::value_type ram_rdata;

   bse_pkg::value_type cmp_lhs, cmp_rhs;
   logic               swap;
   logic [CW-1:0]      span_m1;
   logic               req_accept;
   logic               csr_write;
   logic               csr_hit;

   bse_ram #(
      .WIDTH (bse_pkg::VALUE_W),
      .DEPTH (MAX_ITEMS)
   ) u_store (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   // shared comparator: carry moves right when it orders after the fetched element
   assign cmp_lhs = descending_ff ? ram_rdata : carry_ff;
   assign cmp_rhs = descending_ff ? carry_ff  : ram_rdata;
   assign swap    = cmp_lhs > cmp_rhs;

   assign span_m1    = span_ff - CW'(1);
   assign req_accept = req_chan.valid && req_chan.ready;

   assign csr_pready = 1'b1;
   assign csr_hit    = csr_paddr[bse_pkg::CSR_ADDR_W-1:2] == bse_pkg::REG_DESCENDING;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_prdata = csr_hit ? bse_pkg::CSR_DATA_W'(descending_ff) : '0;

   assign req_chan.ready        = (state_ff == S_IDLE);
   assign rsp_chan.valid        = rsp_valid_ff;
   assign rsp_chan.sorted_value = rsp_value_ff;
   assign rsp_chan.last_out     = rsp_last_ff;
   assign rsp_chan.dropped      = rsp_drop_ff;

   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      overflow_in   = overflow_ff;
      descending_in = descending_ff;
      span_in       = span_ff;
      k_in          = k_ff;
      idx_in        = idx_ff;
      carry_in      = carry_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_value_in  = rsp_value_ff;
      rsp_last_in   = rsp_last_ff;
      rsp_drop_in   = rsp_drop_ff;
      ram_we        = 1'b0;
      ram_waddr     = '0;
      ram_wdata     = req_chan.value;
      ram_raddr     = '0;

      if (csr_write && csr_hit) begin
         descending_in = csr_pwdata[0];
      end

      case (state_ff)
         S_IDLE: begin
            if (req_accept) begin
               if (count_ff < MAX_COUNT) begin
                  ram_we    = 1'b1;
                  ram_waddr = count_ff[AW-1:0];
                  count_in  = count_ff + CW'(1);
               end else begin
                  overflow_in = 1'b1;
               end
               if (req_chan.last_in) begin
                  state_in = S_START;
               end
            end
         end
         S_START: begin
            if (count_ff >= CW'(2)) begin
               span_in  = count_ff;
               state_in = S_CARRY;
            end else begin
               idx_in   = '0;
               state_in = S_OREAD;
            end
         end
         S_CARRY: begin
            carry_in  = ram_rdata;
            k_in      = AW'(1);
            ram_raddr = AW'(1);
            state_in  = S_RUN;
         end
         S_RUN: begin
            ram_we    = 1'b1;
            ram_waddr = k_ff - AW'(1);
            ram_wdata = swap ? ram_rdata : carry_ff;
            carry_in  = swap ? carry_ff : ram_rdata;
            if (CW'(k_ff) == span_m1) begin
               state_in = S_TAIL;
            end else begin
               k_in      = k_ff + AW'(1);
               ram_raddr = k_ff + AW'(1);
            end
         end
         S_TAIL: begin
            ram_we    = 1'b1;
            ram_waddr = span_m1[AW-1:0];
            ram_wdata = carry_ff;
            span_in   = span_m1;
            if (span_m1 >= CW'(2)) begin
               state_in = S_CARRY;     // read of entry 0 issued here
            end else begin
               idx_in   = '0;
               state_in = S_OREAD;
            end
         end
         S_OREAD: begin
            ram_raddr = idx_ff;
            state_in  = S_OLOAD;
         end
         S_OLOAD: begin
            rsp_valid_in = 1'b1;
            rsp_value_in = ram_rdata;
            rsp_last_in  = CW'(idx_ff) == (count_ff - CW'(1));
            rsp_drop_in  = overflow_ff;
            state_in     = S_OSEND;
         end
         S_OSEND: begin
            if (rsp_chan.ready) begin
               rsp_valid_in = 1'b0;
               if (rsp_last_ff) begin
                  count_in    = '0;
                  overflow_in = 1'b0;
                  state_in    = S_IDLE;
               end else begin
                  idx_in   = idx_ff + AW'(1);
                  state_in = S_OREAD;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      span_ff      <= span_in;
      k_ff         <= k_in;
      idx_ff       <= idx_in;
      carry_ff     <= carry_in;
      rsp_value_ff <= rsp_value_in;
      rsp_last_ff  <= rsp_last_in;
      rsp_drop_ff  <= rsp_drop_in;
      if (reset) begin
         state_ff      <= S_IDLE;
         count_ff      <= '0;
         overflow_ff   <= 1'b0;
         descending_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         count_ff      <= count_in;
         overflow_ff   <= overflow_in;
         descending_ff <= descending_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   a_count_bound : assert property (@(posedge clock) disable iff (reset)
      count_ff <= MAX_COUNT)
      else $error("element count beyond capacity");

   a_pass_in_range : assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_RUN) |-> (CW'(k_ff) < span_ff && span_ff >= CW'(2)))
      else $error("compare position outside the current pass");

   a_no_overlap : assert property (@(posedge clock) disable iff (reset)
      !(req_chan.ready && rsp_chan.valid))
      else $error("input ready while a result is pending");

   a_set_cleared : assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && rsp_chan.ready && rsp_chan.last_out)
      |=> (count_ff == '0 && !overflow_ff && state_ff == S_IDLE))
      else $error("set state not cleared after final result");

endmodule

// ===== tb/sv/bubble_sort_engine_tb.sv =====
// Self-checking testbench for bubble_sort_engine: sends sets of signed elements and checks
// each sorted result against a set-collecting predictor held in a small scoreboard class.
// Depends on bse_pkg, bse_req_if, bse_rsp_if and the engine RTL.
`timescale 1ns / 1ps

module bubble_sort_engine_tb;

   localparam int SET_CAPACITY = 64;
   localparam bse_pkg::reg_index_type UNMAPPED_REG = bse_pkg::reg_index_type'(1);
   localparam logic [bse_pkg::CSR_ADDR_W-1:0] DESC_ADDR     = {bse_pkg::REG_DESCENDING, 2'b00};
   localparam logic [bse_pkg::CSR_ADDR_W-1:0] UNMAPPED_ADDR = {UNMAPPED_REG, 2'b00};
   localparam int HOLD_CYCLES = 400;

   typedef struct packed {
      bse_pkg::value_type sorted_value;
      logic               last_out;
      logic               dropped;
   } sorted_item_type;

   // Collects each set as the engine stores it and queues the sorted results it owes.
   class sort_scoreboard;
      bse_pkg::value_type set_store[SET_CAPACITY];
      int                 set_count;
      bit                 set_overflow;
      bit                 descending;
      sorted_item_type    sorted_due[$];
      int                 errors;

      function new();
         set_count = 0;
         set_overflow = 0;
         descending = 0;
         errors = 0;
      endfunction

      function void collect_element(bse_pkg::value_type v, logic last);
         bse_pkg::value_type a;
         bse_pkg::value_type b;
         sorted_item_type it;
         if (set_count < SET_CAPACITY) begin
            set_store[set_count] = v;
            set_count++;
         end else begin
            set_overflow = 1;
         end
         if (!last) return;
         for (int pass = 0; pass < set_count; pass++) begin
            for (int k = 0; k + 1 < set_count - pass; k++) begin
               a = set_store[k];
               b = set_store[k + 1];
               // equal elements never swap, so arrival order holds
               if (descending ? (b > a) : (a > b)) begin
                  set_store[k] = b;
                  set_store[k + 1] = a;
               end
            end
         end
         for (int k = 0; k < set_count; k++) begin
            it.sorted_value = set_store[k];
            it.last_out = (k + 1 == set_count);
            it.dropped = set_overflow;
            sorted_due.push_back(it);
         end
         set_count = 0;
         set_overflow = 0;
      endfunction

      function void check_result(bse_pkg::value_type v, logic last, logic drop);
         sorted_item_type exp_item;
         if (sorted_due.size() == 0) begin
            $display("ERROR %0t: unexpected result item: value %0d last %b dropped %b",
                     $time, v, last, drop);
            errors++;
            return;
         end
         exp_item = sorted_due.pop_front();
         if (exp_item.sorted_value !== v) begin
            $display("ERROR %0t: sorted_value expected %0d actual %0d",
                     $time, exp_item.sorted_value, v);
            errors++;
         end
         if (exp_item.last_out !== last) begin
            $display("ERROR %0t: last_out expected %b actual %b", $time, exp_item.last_out, last);
            errors++;
         end
         if (exp_item.dropped !== drop) begin
            $display("ERROR %0t: dropped expected %b actual %b", $time, exp_item.dropped, drop);
            errors++;
         end
      endfunction

      function int pending();
         return sorted_due.size();
      endfunction
   endclass

   logic clock;
   logic reset;
   logic                           csr_psel;
   logic                           csr_penable;
   logic                           csr_pwrite;
   logic [bse_pkg::CSR_ADDR_W-1:0] csr_paddr;
   logic [bse_pkg::CSR_DATA_W-1:0] csr_pwdata;
   logic [bse_pkg::CSR_DATA_W-1:0] csr_prdata;
   logic                           csr_pready;

   int send_idle_pct;
   int recv_stall_pct;
   bit hold_armed;

   sort_scoreboard book;

   bse_req_if req ();
   bse_rsp_if rsp ();

   bubble_sort_engine #(.MAX_ITEMS(SET_CAPACITY)) dut (
      .clock       (clock),
      .reset       (reset),
      .req_chan    (req),
      .rsp_chan    (rsp),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   initial clock = 0;
   always #5 clock = ~clock;

   // result side: random stalls, plus one long hold when armed
   initial begin
      int hold_left;
      bit hold_used;
      hold_left = 0;
      hold_used = 0;
      rsp.ready = 0;
      forever begin
         @(negedge clock);
         if (reset) begin
            rsp.ready <= 0;
         end else begin
            if (hold_armed && !hold_used) begin
               hold_left = HOLD_CYCLES;
               hold_used = 1;
            end
            if (hold_left > 0) begin
               rsp.ready <= 0;
               hold_left--;
            end else begin
               rsp.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
            end
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp.valid && rsp.ready)
         book.check_result(rsp.sorted_value, rsp.last_out, rsp.dropped);
   end

   initial begin
      #5_000_000;
      $display("Mismatches found");
      $finish;
   end

   function automatic bse_pkg::value_type random_element();
      int pick;
      pick = $urandom_range(0, 9);
      if (pick == 0) begin
         case ($urandom_range(0, 3))
            0: return {1'b1, 31'b0};
            1: return {1'b0, {31{1'b1}}};
            2: return '0;
            default: return '1;
         endcase
      end
      // narrow range to get plenty of equal elements
      if (pick == 1) return bse_pkg::value_type'(int'($urandom_range(0, 8)) - 4);
      return bse_pkg::value_type'($urandom);
   endfunction

   function automatic int random_set_size();
      if ($urandom_range(0, 15) == 0) return int'($urandom_range(40, SET_CAPACITY));
      return int'($urandom_range(1, 8));
   endfunction

   // called at a falling edge, returns at a falling edge
   task automatic send_item(input bse_pkg::value_type v, input logic last);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req.valid <= 0;
         @(negedge clock);
      end
      req.valid <= 1;
      req.value <= v;
      req.last_in <= last;
      do @(posedge clock); while (!req.ready);
      book.collect_element(v, last);
      @(negedge clock);
   endtask

   task automatic send_set(input int n);
      for (int i = 0; i < n; i++) send_item(random_element(), i == n - 1);
   endtask

   task automatic send_values(input bse_pkg::value_type vals[$]);
      foreach (vals[i]) send_item(vals[i], i == vals.size() - 1);
   endtask

   task automatic write_csr(input logic [bse_pkg::CSR_ADDR_W-1:0] addr,
                            input logic [bse_pkg::CSR_DATA_W-1:0] data);
      csr_psel <= 1;
      csr_penable <= 0;
      csr_pwrite <= 1;
      csr_paddr <= addr;
      csr_pwdata <= data;
      @(negedge clock);
      csr_penable <= 1;
      do @(posedge clock); while (!csr_pready);
      if (addr == DESC_ADDR) book.descending = data[0];
      @(negedge clock);
      csr_psel <= 0;
      csr_penable <= 0;
      csr_pwrite <= 0;
   endtask

   task automatic check_order_reg();
      logic [bse_pkg::CSR_DATA_W-1:0] got;
      csr_psel <= 1;
      csr_penable <= 0;
      csr_pwrite <= 0;
      csr_paddr <= DESC_ADDR;
      @(negedge clock);
      csr_penable <= 1;
      do @(posedge clock); while (!csr_pready);
      got = csr_prdata;
      @(negedge clock);
      csr_psel <= 0;
      csr_penable <= 0;
      if (got[0] !== book.descending) begin
         $display("ERROR %0t: descending readback expected %b actual %b",
                  $time, book.descending, got[0]);
         book.errors++;
      end
   endtask

   // wait until every owed result is in and the engine has settled
   task automatic drain();
      req.valid <= 0;
      while (book.pending() != 0) @(negedge clock);
      repeat (8) @(negedge clock);
   endtask

   task automatic run_phase(input bit desc, input int idle_pct, input int stall_pct,
                            input int forced_size, input int budget);
      int sent;
      drain();
      write_csr(DESC_ADDR, bse_pkg::CSR_DATA_W'(desc));
      check_order_reg();
      send_idle_pct = idle_pct;
      recv_stall_pct = stall_pct;
      if (forced_size > 0) send_set(forced_size);
      sent = 0;
      while (sent < budget) begin
         int n;
         n = random_set_size();
         send_set(n);
         sent += n;
      end
   endtask

   initial begin
      bse_pkg::value_type vals[$];
      book = new();
      send_idle_pct = 0;
      recv_stall_pct = 0;
      hold_armed = 0;
      reset = 1;
      req.valid = 0;
      req.value = '0;
      req.last_in = 0;
      csr_psel = 0;
      csr_penable = 0;
      csr_pwrite = 0;
      csr_paddr = '0;
      csr_pwdata = '0;
      repeat (6) @(negedge clock);
      reset <= 0;
      @(negedge clock);

      // ascending from reset: single-element set, extremes, ties
      send_values('{{1'b1, 31'b0}});
      send_values('{{1'b0, {31{1'b1}}}, {1'b1, 31'b0}, 0, -1, 1});
      send_values('{7, 7, -3, 7});
      drain();
      write_csr(DESC_ADDR, 1);
      // a write past the register list must leave the order alone
      write_csr(UNMAPPED_ADDR, 0);
      check_order_reg();
      send_values('{{1'b1, 31'b0}, {1'b0, {31{1'b1}}}, 0, -1, 5, 5});
      send_values('{3, 1, 2});

      // full set, then one where the flagged last element is itself dropped
      run_phase(0, 0, 0, SET_CAPACITY, 15);
      run_phase(1, 49, 0, SET_CAPACITY + 1, 15);
      run_phase(0, 0, 49, 0, 15);
      run_phase(1, 8, 8, 0, 15);

      // long receiver hold while input keeps coming
      drain();
      hold_armed = 1;
      run_phase(0, 0, 0, 0, 15);

      drain();
      repeat (50) @(negedge clock);
      if (book.errors == 0 && book.pending() == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule

// ===== files.f =====
rtl/bse_pkg.sv
rtl/bse_req_if.sv
rtl/bse_rsp_if.sv
rtl/bse_ram.sv
rtl/bubble_sort_engine.sv
tb/sv/bubble_sort_engine_tb.sv
